// ----- sv/first_fit_allocator_coalescing_assert.svh -----
// Assertion macros used by the allocator module.
`ifndef FIRST_FIT_ALLOCATOR_COALESCING_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_COALESCING_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ffa_pkg.sv -----
`default_nettype none
package ffa_pkg;
  localparam int unsigned FreeEntriesDef = 16;
  localparam int unsigned UsedEntriesDef = 16;
  localparam int unsigned AddrBitsDef    = 16;
  localparam logic [15:0] TotalSizeReset = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADADDR = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_size;
    logic [15:0] release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] region_address;
    logic [15:0] region_size;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_A_RD,
    S_A_CHK,
    S_A_SHIFT_RD,
    S_A_SHIFT_WR,
    S_R_RD,
    S_R_CHK,
    S_R_SHIFT_RD,
    S_R_SHIFT_WR,
    S_R_APPEND,
    S_C_RDI,
    S_C_LATI,
    S_C_RDJ,
    S_C_CHK,
    S_C_RDLEN,
    S_C_MERGE,
    S_C_DROP_RD,
    S_C_DROP_WR,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

// ----- sv/first_fit_allocator_coalescing.sv -----
// The result strobe follows the start transfer via S_A_RD and S_DONE for a zero request, a full
// used table or an empty table; a release that merges also passes through the merge states.
// One request at a time; busy stays high until the result cycle ends. Scans and shifts
// visit table entries with a read state and a check or write state, and each merge pass
// checks every pair of free entries. The receiver cannot stall.
// Reset, and each total_size write, rebuilds the free table in the busy state S_INIT.
`default_nettype none
module first_fit_allocator_coalescing import ffa_pkg::*; #(
  parameter int unsigned FREE_ENTRIES = FreeEntriesDef,
  parameter int unsigned USED_ENTRIES = UsedEntriesDef,
  parameter int unsigned ADDR_BITS    = AddrBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             rsp_valid_o,
  output rsp_t             rsp_o
);
`include "first_fit_allocator_coalescing_assert.svh"
  localparam int unsigned FW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int unsigned UW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
  localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned UCW = $clog2(USED_ENTRIES + 1);
  localparam int unsigned AW = ADDR_BITS;

  typedef logic [AW-1:0] a_t;

  function automatic a_t to_a(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[AW-1:0];
  endfunction

  function automatic logic [15:0] to16(input a_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  state_e state_q, state_d;
  logic [15:0] total_q;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [UCW-1:0] ucnt_q, ucnt_d;
  logic [FCW-1:0] i_q, i_d, j_q, j_d;
  logic [UCW-1:0] k_q, k_d;
  req_t req_q;
  a_t   sa_q, sa_d, la_q, la_d;   // region start / length of the current request
  a_t   end_q, end_d;             // end of coalesce entry i
  a_t   li_q, li_d;               // length of coalesce entry i
  a_t   tmp_l_q, tmp_l_d;
  status_e st_q, st_d;

  // Free table port.
  logic         f_we;
  logic [FW-1:0] f_wa, f_ra;
  a_t f_ws, f_wl, f_rs, f_rl;
  // Used table port.
  logic         u_we;
  logic [UW-1:0] u_wa, u_ra;
  a_t u_ws, u_wl, u_rs, u_rl;

  ffa_table #(.Entries(FREE_ENTRIES), .AddrBits(AW)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wstart_i(f_ws), .wlen_i(f_wl),
    .raddr_i(f_ra), .rstart_o(f_rs), .rlen_o(f_rl)
  );
  ffa_table #(.Entries(USED_ENTRIES), .AddrBits(AW)) u_used (
    .clk_i, .we_i(u_we), .waddr_i(u_wa), .wstart_i(u_ws), .wlen_i(u_wl),
    .raddr_i(u_ra), .rstart_o(u_rs), .rlen_o(u_rl)
  );

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      total_q <= TotalSizeReset;
      fcnt_q  <= '0;
      ucnt_q  <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0;
      st_q <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
        state_q <= S_INIT;
      end else begin
        state_q <= state_d;
      end
      fcnt_q <= fcnt_d;
      ucnt_q <= ucnt_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    sa_q <= sa_d; la_q <= la_d; end_q <= end_d; li_q <= li_d;
    tmp_l_q <= tmp_l_d;
  end

  logic [FW-1:0] i_ix, j_ix, jn_ix, fc_ix;
  logic [UW-1:0] k_ix, kn_ix, uc_ix;
  a_t req_a, rel_a, tot_a;
  assign i_ix  = i_q[FW-1:0];
  assign j_ix  = j_q[FW-1:0];
  assign jn_ix = FW'(j_q + 1'b1);
  assign fc_ix = fcnt_q[FW-1:0];
  assign k_ix  = k_q[UW-1:0];
  assign kn_ix = UW'(k_q + 1'b1);
  assign uc_ix = ucnt_q[UW-1:0];
  assign req_a = to_a(req_q.request_size);
  assign rel_a = to_a(req_q.release_address);
  assign tot_a = to_a(total_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (start) state_d = (req_i.kind == KIND_ALLOC) ? S_A_RD : S_R_RD;
      end
      S_A_RD: begin
        if (req_a == '0 || ucnt_q >= UCW'(USED_ENTRIES) || j_q >= fcnt_q)
          state_d = S_DONE;
        else state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (f_rl >= req_a) state_d = (f_rl == req_a) ? S_A_SHIFT_RD : S_DONE;
        else state_d = S_A_RD;
      end
      S_A_SHIFT_RD: state_d = (j_q + 1'b1 < fcnt_q) ? S_A_SHIFT_WR : S_DONE;
      S_A_SHIFT_WR: state_d = S_A_SHIFT_RD;
      S_R_RD: state_d = (k_q < ucnt_q) ? S_R_CHK : S_DONE;
      S_R_CHK: begin
        if (u_rs == rel_a) begin
          state_d = (fcnt_q >= FCW'(FREE_ENTRIES)) ? S_DONE : S_R_SHIFT_RD;
        end else state_d = S_R_RD;
      end
      S_R_SHIFT_RD: state_d = (k_q + 1'b1 < ucnt_q) ? S_R_SHIFT_WR : S_R_APPEND;
      S_R_SHIFT_WR: state_d = S_R_SHIFT_RD;
      S_R_APPEND: state_d = S_C_RDI;
      S_C_RDI: state_d = (i_q < fcnt_q) ? S_C_LATI : S_DONE;
      S_C_LATI: state_d = S_C_RDJ;
      S_C_RDJ: state_d = (j_q < fcnt_q) ? S_C_CHK : S_C_RDI;
      S_C_CHK: state_d = (f_rs == end_q) ? S_C_MERGE : S_C_RDJ;
      S_C_MERGE: state_d = S_C_DROP_RD;
      S_C_DROP_RD: state_d = (j_q + 1'b1 < fcnt_q) ? S_C_DROP_WR : S_C_RDI;
      S_C_DROP_WR: state_d = S_C_DROP_RD;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    fcnt_d = fcnt_q; ucnt_d = ucnt_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    sa_d = sa_q; la_d = la_q; end_d = end_q; li_d = li_q;
    tmp_l_d = tmp_l_q; st_d = st_q;
    f_we = 1'b0; f_wa = '0; f_ws = '0; f_wl = '0; f_ra = '0;
    u_we = 1'b0; u_wa = '0; u_ws = '0; u_wl = '0; u_ra = '0;
    case (state_q)
      S_INIT: begin
        f_we = 1'b1; f_ws = '0; f_wl = tot_a;
        fcnt_d = (tot_a != '0) ? FCW'(1) : '0;
        ucnt_d = '0;
      end
      S_IDLE: begin
        k_d = '0; i_d = '0; j_d = '0;
      end
      S_A_RD: begin
        f_ra = j_ix;
        if (req_a == '0) st_d = ST_NOSPACE;
        else if (ucnt_q >= UCW'(USED_ENTRIES)) st_d = ST_FULL;
        else if (j_q >= fcnt_q) st_d = ST_NOSPACE;
      end
      S_A_CHK: begin
        if (f_rl >= req_a) begin
          st_d = ST_OK; sa_d = f_rs; la_d = req_a;
          u_we = 1'b1; u_wa = uc_ix; u_ws = f_rs; u_wl = req_a;
          ucnt_d = ucnt_q + 1'b1;
          f_we = 1'b1; f_wa = j_ix;
          f_ws = f_rs + req_a; f_wl = f_rl - req_a;
        end else j_d = j_q + 1'b1;
      end
      S_A_SHIFT_RD: begin
        f_ra = jn_ix;
        if (!(j_q + 1'b1 < fcnt_q)) fcnt_d = fcnt_q - 1'b1;
      end
      S_A_SHIFT_WR: begin
        f_we = 1'b1; f_wa = j_ix; f_ws = f_rs; f_wl = f_rl;
        j_d = j_q + 1'b1;
      end
      S_R_RD: begin
        u_ra = k_ix;
        if (!(k_q < ucnt_q)) st_d = ST_BADADDR;
      end
      S_R_CHK: begin
        if (u_rs == rel_a) begin
          sa_d = rel_a; la_d = u_rl;
          st_d = (fcnt_q >= FCW'(FREE_ENTRIES)) ? ST_FULL : ST_OK;
        end else k_d = k_q + 1'b1;
      end
      S_R_SHIFT_RD: begin
        u_ra = kn_ix;
        if (!(k_q + 1'b1 < ucnt_q)) ucnt_d = ucnt_q - 1'b1;
      end
      S_R_SHIFT_WR: begin
        u_we = 1'b1; u_wa = k_ix; u_ws = u_rs; u_wl = u_rl;
        k_d = k_q + 1'b1;
      end
      S_R_APPEND: begin
        f_we = 1'b1; f_wa = fc_ix; f_ws = sa_q; f_wl = la_q;
        fcnt_d = fcnt_q + 1'b1;
        i_d = '0;
      end
      S_C_RDI: begin
        f_ra = i_ix;
        j_d = '0;
      end
      S_C_LATI: begin
        end_d = f_rs + f_rl; li_d = f_rl;
      end
      S_C_RDJ: begin
        f_ra = j_ix;
        if (!(j_q < fcnt_q)) i_d = i_q + 1'b1;
      end
      S_C_CHK: begin
        if (f_rs == end_q) tmp_l_d = f_rl;
        else j_d = j_q + 1'b1;
      end
      S_C_MERGE: begin
        // Entry i keeps its start; its length grows by entry j's.
        f_ra = i_ix;
        f_we = 1'b1; f_wa = i_ix; f_ws = end_q - li_q; f_wl = li_q + tmp_l_q;
      end
      S_C_DROP_RD: begin
        f_ra = jn_ix;
        if (!(j_q + 1'b1 < fcnt_q)) begin
          fcnt_d = fcnt_q - 1'b1; i_d = '0;
        end
      end
      S_C_DROP_WR: begin
        f_we = 1'b1; f_wa = j_ix; f_ws = f_rs; f_wl = f_rl;
        j_d = j_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = (state_q == S_DONE);
  always_comb begin
    rsp_o.status = st_q;
    rsp_o.region_address = (st_q == ST_OK) ? to16(sa_q) : '0;
    rsp_o.region_size    = (st_q == ST_OK) ? to16(la_q) : '0;
  end

  `FFA_ASSERT_IMP(a_cnt_free, clk_i, rst_ni, 1'b1, fcnt_q <= FCW'(FREE_ENTRIES),
    "free count overflow")
  `FFA_ASSERT_IMP(a_cnt_used, clk_i, rst_ni, 1'b1, ucnt_q <= UCW'(USED_ENTRIES),
    "used count overflow")
  `FFA_ASSERT_NEXT(a_one_rsp, clk_i, rst_ni, rsp_valid_o, !rsp_valid_o && !busy,
    "response not single")
  `FFA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy && !cfg_we_i, busy,
    "accepted start did not go busy")
endmodule
`default_nettype wire

// ----- sv/ffa_table.sv -----
`default_nettype none
// Table of (start, length) pairs, one write and one registered read per cycle.
module ffa_table import ffa_pkg::*; #(
  parameter int unsigned Entries  = FreeEntriesDef,
  parameter int unsigned AddrBits = AddrBitsDef,
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [IdxW-1:0]     waddr_i,
  input  wire logic [AddrBits-1:0] wstart_i,
  input  wire logic [AddrBits-1:0] wlen_i,
  input  wire logic [IdxW-1:0]     raddr_i,
  output logic      [AddrBits-1:0] rstart_o,
  output logic      [AddrBits-1:0] rlen_o
);
  logic [2*AddrBits-1:0] mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wlen_i};
    end
    {rstart_o, rlen_o} <= mem[raddr_i];
  end
endmodule
`default_nettype wire
